/* src/hsvf_pkg.sv */
// Shared constants, payload types and register indexes for the HSV floor core.
`default_nettype none
package hsvf_pkg;

  // Hue fraction bits (sector fraction resolution), valid from 10 to 24.
  localparam int FRAC_BITS = 16;

  // Saturation is Q1.16, 1.0 is 65536.
  localparam int SAT_W = 17;
  localparam logic [SAT_W-1:0] SAT_ONE = 17'h10000;

  // Configuration port.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 17;
  localparam logic [CFG_IDX_W-1:0] REG_SAT_FLOOR   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_VALUE_FLOOR = 2'd1;
  localparam logic [SAT_W-1:0] SAT_FLOOR_RESET   = 17'd32768;
  localparam logic [7:0]       VALUE_FLOOR_RESET = 8'd153;

  // Divider: dividend is num * 2^DIV_K with num below 8 * den.
  localparam int NUM_W      = 11;
  localparam int DIV_K      = (FRAC_BITS > 16) ? FRAC_BITS : 16;
  localparam int DIV_QW     = DIV_K + 3;
  localparam int DIV_STEP_N = 4;
  localparam int DIV_STAGES = (DIV_QW + DIV_STEP_N - 1) / DIV_STEP_N;

  typedef struct packed {
    logic [7:0] in_red;
    logic [7:0] in_green;
    logic [7:0] in_blue;
  } pixel_in_t;

  typedef struct packed {
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
  } pixel_out_t;

endpackage
`default_nettype wire

/* src/hsv_saturation_value_floor_core.sv */
// Top level: RGB to HSV, saturation and value floor, HSV back to RGB.
`default_nettype none
// Throughput: one pixel word per clock; busy stays low, start is always taken.
// Pipeline: stages 0 to 2, the stages of the two pipelined dividers, then P1
//   to P3 and the result register behind the P4 channel pick.
// Results show for one cycle under result_strobe; the receiver cannot stall.
// Reset (rst, synchronous): clears all stage valid bits and loads the floors
//   with 32768 (saturation) and 153 (value).
module hsv_saturation_value_floor_core (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  hsvf_pkg::pixel_in_t              pixel,
  output logic                             result_strobe,
  output hsvf_pkg::pixel_out_t             result,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [hsvf_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [hsvf_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import hsvf_pkg::*;

  // Hue sectors, red toward yellow first.
  localparam logic [2:0] SEC_RY = 3'd0;
  localparam logic [2:0] SEC_YG = 3'd1;
  localparam logic [2:0] SEC_GC = 3'd2;
  localparam logic [2:0] SEC_CB = 3'd3;
  localparam logic [2:0] SEC_BM = 3'd4;

  localparam int S_SHIFT = DIV_K - 16;
  localparam int H_SHIFT = DIV_K - FRAC_BITS;
  localparam int PW      = FRAC_BITS + 17;   // width of scaled f*S terms
  localparam logic [PW-1:0]   FULL   = {1'b1, {(PW-1){1'b0}}};
  localparam logic [FRAC_BITS:0] ONE_F = {1'b1, {FRAC_BITS{1'b0}}};
  localparam logic [PW+7:0]   HALF_Q = (PW+8)'(1) << (FRAC_BITS + 15);
  localparam logic [24:0]     HALF_P = 25'h0_8000;

  // Configuration registers; always ready.
  logic [SAT_W-1:0] sat_floor;
  logic [7:0]       value_floor;

  assign cfg_ready = 1'b1;
  assign busy      = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      sat_floor   <= SAT_FLOOR_RESET;
      value_floor <= VALUE_FLOOR_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_SAT_FLOOR:   sat_floor   <= cfg_data[SAT_W-1:0];
        REG_VALUE_FLOOR: value_floor <= cfg_data[7:0];
        default: ;  // drop writes to unknown indexes
      endcase
    end
  end

  // Stage 0: capture the input word.
  logic      s0_valid;
  pixel_in_t s0_pix;

  // Stage 1: max and min.
  logic       s1_valid;
  logic [7:0] s1_r, s1_g, s1_b, s1_mx, s1_mn;

  // Stage 2: chroma and hue numerator.
  logic              s2_valid;
  logic [7:0]        s2_mx, s2_delta;
  logic [NUM_W-1:0]  s2_num;

  logic [7:0] mx_c, mn_c;
  logic [NUM_W-1:0] r11, g11, b11, d11, num_c;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      s0_valid <= start & ~busy;
      s1_valid <= s0_valid;
      s2_valid <= s1_valid;
    end
  end

  always_comb begin
    mx_c = s0_pix.in_red;
    mn_c = s0_pix.in_red;
    if (s0_pix.in_green > mx_c) mx_c = s0_pix.in_green;
    if (s0_pix.in_blue  > mx_c) mx_c = s0_pix.in_blue;
    if (s0_pix.in_green < mn_c) mn_c = s0_pix.in_green;
    if (s0_pix.in_blue  < mn_c) mn_c = s0_pix.in_blue;
  end

  // Hue numerator: sector offset times chroma plus channel difference,
  // kept nonnegative so the divider never sees a sign.
  always_comb begin
    r11 = {3'b0, s1_r};
    g11 = {3'b0, s1_g};
    b11 = {3'b0, s1_b};
    d11 = {3'b0, 8'(s1_mx - s1_mn)};
    if (s1_mx == s1_r) begin
      if (s1_g >= s1_b) num_c = g11 - b11;
      else              num_c = (d11 << 2) + (d11 << 1) - (b11 - g11);
    end else if (s1_mx == s1_g) begin
      num_c = (d11 << 1) + b11 - r11;
    end else begin
      num_c = (d11 << 2) + r11 - g11;
    end
  end

  always_ff @(posedge clk) begin
    s0_pix   <= pixel;
    s1_r     <= s0_pix.in_red;
    s1_g     <= s0_pix.in_green;
    s1_b     <= s0_pix.in_blue;
    s1_mx    <= mx_c;
    s1_mn    <= mn_c;
    s2_mx    <= s1_mx;
    s2_delta <= 8'(s1_mx - s1_mn);
    s2_num   <= num_c;
  end

  // Dividers: S = delta*2^16/max, H = num*2^FRAC/delta. A zero divisor only
  // comes with a zero dividend, so force it to one to get a zero quotient.
  logic [DIV_QW-1:0] quo_s, quo_h;

  hsvf_div u_div_sat (
    .clk (clk),
    .num ({3'b0, s2_delta}),
    .den ((s2_mx == 8'd0) ? 8'd1 : s2_mx),
    .quo (quo_s)
  );

  hsvf_div u_div_hue (
    .clk (clk),
    .num (s2_num),
    .den ((s2_delta == 8'd0) ? 8'd1 : s2_delta),
    .quo (quo_h)
  );

  // Carry valid and max alongside the divider stages.
  logic       dly_valid [DIV_STAGES];
  logic [7:0] dly_mx    [DIV_STAGES];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < DIV_STAGES; i++) dly_valid[i] <= 1'b0;
    end else begin
      dly_valid[0] <= s2_valid;
      for (int i = 1; i < DIV_STAGES; i++) dly_valid[i] <= dly_valid[i-1];
    end
  end

  always_ff @(posedge clk) begin
    dly_mx[0] <= s2_mx;
    for (int i = 1; i < DIV_STAGES; i++) dly_mx[i] <= dly_mx[i-1];
  end

  // P1: scale quotients, apply the floors, split hue.
  logic                 p1_valid;
  logic [7:0]           p1_v;
  logic [SAT_W-1:0]     p1_s;
  logic [2:0]           p1_sector;
  logic [FRAC_BITS-1:0] p1_f;

  logic [DIV_QW-1:0] s_scaled, h_scaled;
  logic [SAT_W-1:0]  sat_c, sf_c;
  logic [7:0]        v_c;

  always_comb begin
    s_scaled = quo_s >> S_SHIFT;
    h_scaled = quo_h >> H_SHIFT;
    sf_c     = (sat_floor > SAT_ONE) ? SAT_ONE : sat_floor;
    sat_c    = s_scaled[SAT_W-1:0];
    if (sat_c < sf_c) sat_c = sf_c;
    v_c      = dly_mx[DIV_STAGES-1];
    if (v_c < value_floor) v_c = value_floor;
  end

  always_ff @(posedge clk) begin
    p1_v      <= v_c;
    p1_s      <= sat_c;
    p1_sector <= h_scaled[FRAC_BITS +: 3];
    p1_f      <= h_scaled[FRAC_BITS-1:0];
  end

  // P2: first products, f*S, (1-f)*S and V*(1-S).
  logic             p2_valid;
  logic [7:0]       p2_v;
  logic [2:0]       p2_sector;
  logic             p2_szero;
  logic [PW-1:0]    p2_fs, p2_fcs;
  logic [24:0]      p2_pn;

  logic [PW:0]      fcs_wide;

  always_comb begin
    fcs_wide = (PW+1)'(ONE_F - {1'b0, p1_f}) * (PW+1)'(p1_s);
  end

  always_ff @(posedge clk) begin
    p2_v      <= p1_v;
    p2_sector <= p1_sector;
    p2_szero  <= (p1_s == '0);
    p2_fs     <= PW'(p1_f) * PW'(p1_s);
    p2_fcs    <= fcs_wide[PW-1:0];
    p2_pn     <= 25'(p1_v) * 25'(SAT_ONE - p1_s);
  end

  // P3: scale by V and round to nearest, ties up.
  logic       p3_valid;
  logic [7:0] p3_v, p3_pv, p3_qv, p3_tv;
  logic [2:0] p3_sector;
  logic       p3_szero;

  logic [PW+7:0] qn_c, tn_c;
  logic [24:0]   pn_c;

  always_comb begin
    qn_c = (PW+8)'(p2_v) * (PW+8)'(FULL - p2_fs) + HALF_Q;
    tn_c = (PW+8)'(p2_v) * (PW+8)'(FULL - p2_fcs) + HALF_Q;
    pn_c = p2_pn + HALF_P;
  end

  always_ff @(posedge clk) begin
    p3_v      <= p2_v;
    p3_sector <= p2_sector;
    p3_szero  <= p2_szero;
    p3_pv     <= pn_c[23:16];
    p3_qv     <= qn_c[FRAC_BITS+23:FRAC_BITS+16];
    p3_tv     <= tn_c[FRAC_BITS+23:FRAC_BITS+16];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid      <= 1'b0;
      p2_valid      <= 1'b0;
      p3_valid      <= 1'b0;
      result_strobe <= 1'b0;
    end else begin
      p1_valid      <= dly_valid[DIV_STAGES-1];
      p2_valid      <= p1_valid;
      p3_valid      <= p2_valid;
      result_strobe <= p3_valid;
    end
  end

  // P4: pick channels by sector; zero saturation gives gray at V.
  pixel_out_t res_c;

  always_comb begin
    if (p3_szero) begin
      res_c = '{out_red: p3_v, out_green: p3_v, out_blue: p3_v};
    end else begin
      case (p3_sector)
        SEC_RY:  res_c = '{out_red: p3_v,  out_green: p3_tv, out_blue: p3_pv};
        SEC_YG:  res_c = '{out_red: p3_qv, out_green: p3_v,  out_blue: p3_pv};
        SEC_GC:  res_c = '{out_red: p3_pv, out_green: p3_v,  out_blue: p3_tv};
        SEC_CB:  res_c = '{out_red: p3_pv, out_green: p3_qv, out_blue: p3_v};
        SEC_BM:  res_c = '{out_red: p3_tv, out_green: p3_pv, out_blue: p3_v};
        default: res_c = '{out_red: p3_v,  out_green: p3_pv, out_blue: p3_qv};
      endcase
    end
  end

  always_ff @(posedge clk) begin
    result <= res_c;
  end

endmodule
`default_nettype wire

/* src/hsvf_div.sv */
// Pipelined restoring divider, a few quotient bits per stage.
`default_nettype none
module hsvf_div (
  input  logic                        clk,
  input  logic [hsvf_pkg::NUM_W-1:0]  num,
  input  logic [7:0]                  den,
  output logic [hsvf_pkg::DIV_QW-1:0] quo
);
  import hsvf_pkg::*;

  logic [7:0]        rem_s  [DIV_STAGES];
  logic [7:0]        den_s  [DIV_STAGES];
  logic [DIV_QW-1:0] feed_s [DIV_STAGES];
  logic [DIV_QW-1:0] quo_s  [DIV_STAGES];

  for (genvar st = 0; st < DIV_STAGES; st++) begin : g_stage
    logic [7:0]        rem_in;
    logic [7:0]        den_in;
    logic [DIV_QW-1:0] feed_in;
    logic [DIV_QW-1:0] quo_in;
    logic [7:0]        rem_out;
    logic [DIV_QW-1:0] feed_out;
    logic [DIV_QW-1:0] quo_out;
    logic [8:0]        trial;

    if (st == 0) begin : g_first
      // num below 8*den, so its upper bits are already a partial remainder
      assign rem_in  = num[NUM_W-1:3];
      assign den_in  = den;
      assign feed_in = {num[2:0], {DIV_K{1'b0}}};
      assign quo_in  = '0;
    end else begin : g_rest
      assign rem_in  = rem_s[st-1];
      assign den_in  = den_s[st-1];
      assign feed_in = feed_s[st-1];
      assign quo_in  = quo_s[st-1];
    end

    always_comb begin
      rem_out  = rem_in;
      feed_out = feed_in;
      quo_out  = quo_in;
      trial    = '0;
      for (int k = 0; k < DIV_STEP_N; k++) begin
        if (st * DIV_STEP_N + k < DIV_QW) begin
          trial    = {rem_out, feed_out[DIV_QW-1]};
          feed_out = feed_out << 1;
          if (trial >= {1'b0, den_in}) begin
            rem_out = 8'(trial - {1'b0, den_in});
            quo_out = {quo_out[DIV_QW-2:0], 1'b1};
          end else begin
            rem_out = trial[7:0];
            quo_out = {quo_out[DIV_QW-2:0], 1'b0};
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      rem_s[st]  <= rem_out;
      den_s[st]  <= den_in;
      feed_s[st] <= feed_out;
      quo_s[st]  <= quo_out;
    end
  end

  assign quo = quo_s[DIV_STAGES-1];

endmodule
`default_nettype wire

/* test/tb_hsv_saturation_value_floor_core.sv */
// Self-checking testbench for the HSV saturation and value floor core.
`default_nettype none
module tb_hsv_saturation_value_floor_core;
  import hsvf_pkg::*;

  // Register indexes that map to nothing; writes there must leave both floors alone.
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_LO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_HI = 2'd3;
  // Cap on mismatch lines so a broken build does not flood the log.
  localparam int SHOW_LIMIT = 40;

  // Mirror of the floor registers, plus a queue of the pixels the core owes us.
  class hsv_floor_scoreboard;
    logic [SAT_W-1:0] sat_floor;
    logic [7:0]       val_floor;
    pixel_out_t       owed_pixels[$];
    int               errors;
    int               pixels_seen;
    int               results_checked;
    int               reg_writes;

    function new();
      sat_floor       = SAT_FLOOR_RESET;
      val_floor       = VALUE_FLOOR_RESET;
      errors          = 0;
      pixels_seen     = 0;
      results_checked = 0;
      reg_writes      = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      reg_writes++;
      case (idx)
        REG_SAT_FLOOR: begin
          sat_floor = data;
        end
        REG_VALUE_FLOOR: begin
          val_floor = data[7:0];
        end
        default: begin
        end
      endcase
    endfunction

    // RGB -> HSV, raise S and V to their floors, then back to RGB with rounding.
    function pixel_out_t floor_pixel(pixel_in_t px);
      int unsigned     r, g, b, mx, mn, delta, v, s, sf, num, sector;
      longint unsigned hue, f, full, qn, tn, pv, qv, tv, ro, go, bo;
      pixel_out_t      o;
      r = 32'(px.in_red);
      g = 32'(px.in_green);
      b = 32'(px.in_blue);
      mx = r;
      mn = r;
      if (g > mx) mx = g;
      if (b > mx) mx = b;
      if (g < mn) mn = g;
      if (b < mn) mn = b;
      delta = mx - mn;
      v = mx;
      s = (mx != 0) ? 32'((64'(delta) << 16) / mx) : 0;
      // Hue stays zero for gray; otherwise place it as sector offset plus fraction.
      hue = 0;
      if (delta != 0) begin
        if (mx == r) num = (g >= b) ? (g - b) : (6 * delta - (b - g));
        else if (mx == g) num = 2 * delta + b - r;
        else num = 4 * delta + r - g;
        hue = (64'(num) << FRAC_BITS) / delta;
      end
      // A floor above 1.0 clamps to 1.0.
      sf = (sat_floor > SAT_ONE) ? 32'(SAT_ONE) : 32'(sat_floor);
      if (s < sf) s = sf;
      if (v < val_floor) v = 32'(val_floor);
      if (s == 0) begin
        ro = 64'(v);
        go = 64'(v);
        bo = 64'(v);
      end else begin
        sector = 32'(hue >> FRAC_BITS);
        f      = hue & ((64'd1 << FRAC_BITS) - 1);
        full   = 64'd1 << (16 + FRAC_BITS);
        pv = (64'(v) * (32'd65536 - s) + (64'd1 << 15)) >> 16;
        qn = 64'(v) * (full - f * s);
        tn = 64'(v) * (full - ((64'd1 << FRAC_BITS) - f) * s);
        qv = (qn + (64'd1 << (15 + FRAC_BITS))) >> (16 + FRAC_BITS);
        tv = (tn + (64'd1 << (15 + FRAC_BITS))) >> (16 + FRAC_BITS);
        case (sector)
          0: begin ro = 64'(v); go = tv;      bo = pv;      end
          1: begin ro = qv;      go = 64'(v); bo = pv;      end
          2: begin ro = pv;      go = 64'(v); bo = tv;      end
          3: begin ro = pv;      go = qv;      bo = 64'(v); end
          4: begin ro = tv;      go = pv;      bo = 64'(v); end
          default: begin ro = 64'(v); go = pv; bo = qv; end
        endcase
      end
      o.out_red   = 8'(ro);
      o.out_green = 8'(go);
      o.out_blue  = 8'(bo);
      return o;
    endfunction

    function void note_pixel(pixel_in_t px);
      pixels_seen++;
      owed_pixels.push_back(floor_pixel(px));
    endfunction

    function void report_field(string name, logic [7:0] want, logic [7:0] got);
      if (want !== got) begin
        errors++;
        if (errors <= SHOW_LIMIT)
          $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
      end
    endfunction

    function void check_result(pixel_out_t got);
      pixel_out_t want;
      if (owed_pixels.size() == 0) begin
        errors++;
        if (errors <= SHOW_LIMIT)
          $display("%0t: unexpected result word, expected none actual %h", $time, got);
      end else begin
        want = owed_pixels.pop_front();
        results_checked++;
        report_field("out_red", want.out_red, got.out_red);
        report_field("out_green", want.out_green, got.out_green);
        report_field("out_blue", want.out_blue, got.out_blue);
      end
    endfunction

    function int pending();
      return owed_pixels.size();
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  start = 1'b0;
  logic                  busy;
  pixel_in_t             pixel = '0;
  logic                  result_strobe;
  pixel_out_t            result;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  hsv_floor_scoreboard sb = new();
  int                  floor_settings = 1;

  hsv_saturation_value_floor_core uut (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .pixel         (pixel),
    .result_strobe (result_strobe),
    .result        (result),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always #2 clk = ~clk;

  // Sample every handshake at the edge that completes it. Check results before
  // noting new pixels; with a multi-cycle pipeline the two never pair up anyway.
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_valid && cfg_ready) sb.write_reg(cfg_index, cfg_data);
      if (result_strobe) sb.check_result(result);
      if (start && !busy) sb.note_pixel(pixel);
    end
  end

  // Hold start and the word until the core takes it; leave start high so a
  // following word in the same burst goes out back to back.
  task automatic send_pixel(pixel_in_t p);
    start <= 1'b1;
    pixel <= p;
    do @(posedge clk); while (busy);
  endtask

  // Drop start for a gap; put junk on the pixel bus, which must be ignored.
  task automatic pause_sender(int cycles);
    if (cycles > 0) begin
      start <= 1'b0;
      pixel <= pixel_in_t'($urandom);
      repeat (cycles) @(posedge clk);
    end
  endtask

  // Drop start and wait until every owed result word has come back.
  task automatic drain_results();
    start <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // One register write; cfg_valid stays high so writes can go back to back.
  task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // Load both floors while idle. Junk rides in the unused upper bits of the
  // value floor word; a stray write to an unmapped index may follow.
  task automatic set_floors(logic [SAT_W-1:0] sat, logic [7:0] val, bit stray);
    logic [CFG_DATA_W-1:0] val_word;
    val_word       = CFG_DATA_W'($urandom);
    val_word[7:0]  = val;
    write_cfg(REG_SAT_FLOOR, CFG_DATA_W'(sat));
    write_cfg(REG_VALUE_FLOOR, val_word);
    if (stray)
      write_cfg($urandom_range(0, 1) ? REG_UNMAPPED_LO : REG_UNMAPPED_HI,
                CFG_DATA_W'($urandom));
    cfg_valid <= 1'b0;
    floor_settings++;
  endtask

  function automatic logic [7:0] corner_channel();
    case ($urandom_range(0, 3))
      0: return 8'd0;
      1: return 8'd1;
      2: return 8'd254;
      default: return 8'd255;
    endcase
  endfunction

  // Mix of fully random pixels, grays, channel extremes, dim pixels and ties
  // between two channels (which can exercise the red/green/blue priority on max).
  function automatic pixel_in_t random_pixel();
    pixel_in_t p;
    int        kind;
    kind = $urandom_range(0, 99);
    p = pixel_in_t'($urandom);
    if (kind >= 55 && kind < 67) begin
      p.in_green = p.in_red;
      p.in_blue  = p.in_red;
    end else if (kind >= 67 && kind < 82) begin
      p.in_red   = corner_channel();
      p.in_green = corner_channel();
      p.in_blue  = corner_channel();
    end else if (kind >= 82 && kind < 92) begin
      p.in_red   = 8'($urandom_range(0, 7));
      p.in_green = 8'($urandom_range(0, 7));
      p.in_blue  = 8'($urandom_range(0, 7));
    end else if (kind >= 92) begin
      case ($urandom_range(0, 2))
        0: p.in_green = p.in_red;
        1: p.in_blue = p.in_green;
        default: p.in_blue = p.in_red;
      endcase
    end
    return p;
  endfunction

  // Random words in bursts with random gaps; halfway through, wait for the
  // pipeline to empty. A steady run sends back to back with no gaps but that drain.
  task automatic run_random(int count, bit steady);
    int burst_left;
    burst_left = $urandom_range(1, 40);
    for (int i = 0; i < count; i++) begin
      if (i == count / 2) drain_results();
      send_pixel(random_pixel());
      burst_left--;
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 40);
        if (!steady)
          pause_sender(($urandom_range(0, 3) == 0) ? $urandom_range(8, 30)
                                                   : $urandom_range(1, 4));
      end
    end
  endtask

  initial begin
    // Black, white, gray, primaries, secondaries, sector edges, mixed hues and
    // near-black / near-white pixels, all under the reset floors.
    logic [23:0] reset_floor_words[17] = '{
      24'h000000, 24'hFFFFFF, 24'h808080, 24'hFF0000, 24'h00FF00, 24'h0000FF,
      24'hFFFF00, 24'h00FFFF, 24'hFF00FF, 24'hFF0001, 24'hFF0100, 24'h00FF01,
      24'h0100FF, 24'hC86432, 24'h3264C8, 24'h010000, 24'hFEFFFF
    };
    // With both floors at zero: black and gray keep zero saturation, so the
    // output stays gray; the rest checks plain round trips and a tie for the minimum.
    logic [23:0] zero_floor_words[5] = '{
      24'h000000, 24'h4D4D4D, 24'h0A0503, 24'hFFFFFF, 24'h80FF80
    };

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (reset_floor_words[i]) send_pixel(pixel_in_t'(reset_floor_words[i]));
    run_random(200, 1'b0);

    drain_results();
    set_floors('0, 8'd0, 1'b1);
    foreach (zero_floor_words[i]) send_pixel(pixel_in_t'(zero_floor_words[i]));
    run_random(250, 1'b1);

    drain_results();
    set_floors(SAT_ONE, 8'd255, 1'b0);
    run_random(200, 1'b0);

    // Saturation floor beyond 1.0, all bits set.
    drain_results();
    set_floors({SAT_W{1'b1}}, 8'd0, 1'b1);
    run_random(200, 1'b0);

    drain_results();
    set_floors('0, 8'd255, 1'b0);
    run_random(200, 1'b0);

    drain_results();
    set_floors(SAT_W'(1), 8'd1, 1'b1);
    run_random(200, 1'b0);

    drain_results();
    set_floors(SAT_W'(65535), 8'd128, 1'b0);
    run_random(200, 1'b0);

    drain_results();
    set_floors(SAT_W'($urandom_range(0, 131071)), 8'($urandom), 1'b1);
    run_random(180, 1'b0);

    drain_results();
    set_floors(SAT_W'($urandom_range(0, 65536)), 8'($urandom), 1'b0);
    run_random(200, 1'b0);

    // Wait out the pipeline so a late or spurious word still gets caught.
    drain_results();
    repeat (DIV_STAGES + 12) @(posedge clk);

    $display("Covered %0d pixel words over %0d floor settings, %0d register writes.",
             sb.pixels_seen, floor_settings, sb.reg_writes);
    $display("Compared %0d result words; %0d field errors, %0d words still owed.",
             sb.results_checked, sb.errors, sb.pending());
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #2000000;
    $display("Timeout with %0d result words still owed.", sb.pending());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
`default_nettype wire
